FILE: rtl/sorted_deadline_timer_bank_core_defines.svh
// Assertion macros for the sorted deadline timer bank.
`ifndef SORTED_DEADLINE_TIMER_BANK_CORE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_BANK_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent checked in the next cycle.
`define SDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sdtb_pkg.sv
// Package: constants, payload structs and command codes of the timer bank.
package sdtb_pkg;

  localparam int unsigned TimerCount = 8;
  localparam int unsigned IdW        = $clog2(TimerCount);
  localparam int unsigned LenW       = $clog2(TimerCount + 1);
  localparam int unsigned PeriodW    = 31;
  localparam int unsigned TickW      = 32;
  localparam logic [TickW-1:0] TickHalf = 32'h7FFF_FFFF;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    CmdTick      = 3'd0,
    CmdInit      = 3'd1,
    CmdStart     = 3'd2,
    CmdStop      = 3'd3,
    CmdSetPeriod = 3'd4,
    CmdSetMode   = 3'd5,
    CmdReadPer   = 3'd6,
    CmdNone      = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [2:0]         timer_id;
    logic [PeriodW-1:0] period_value;
    logic               periodic_mode;
  } req_t;

  typedef struct packed {
    logic               status;
    logic               expired;
    logic [2:0]         expired_id;
    logic [PeriodW-1:0] read_period;
    logic               last;
  } rsp_t;

  // Classified request passed from front to back.
  typedef struct packed {
    cmd_e               cmd;
    logic [IdW-1:0]     id;
    logic [PeriodW-1:0] pval;
    logic               pmode;
  } op_t;

endpackage

FILE: rtl/sdtb_front.sv
// Front end: accepts requests, classifies them and queues operations.
module sdtb_front
  import sdtb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic op_valid_o,
  input  logic op_ready_i,
  output op_t  op_o
);

  op_t                          fifo_q [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wr_q, rd_q;
  logic [$clog2(QueueDepth+1)-1:0] cnt_q;
  op_t  cls;
  logic push, pop;

  // Classify: out-of-range ids and unused codes become no-ops.
  always_comb begin
    cls.cmd   = cmd_e'(req_i.command);
    cls.id    = IdW'(req_i.timer_id);
    cls.pval  = req_i.period_value;
    cls.pmode = req_i.periodic_mode;
    if (req_i.command != CmdTick && 32'(req_i.timer_id) >= TimerCount) begin
      cls.cmd = CmdNone;
    end
  end

  assign req_ready_o = (cnt_q != ($clog2(QueueDepth+1))'(QueueDepth));
  assign push        = req_valid_i && req_ready_o;
  assign op_valid_o  = (cnt_q != '0);
  assign pop         = op_valid_o && op_ready_i;
  assign op_o        = fifo_q[rd_q];

  // Queue pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= cls;
  end

endmodule

FILE: rtl/sdtb_back.sv
// Back end: timer state, ordered deadline list and result generation.
module sdtb_back
  import sdtb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic op_valid_i,
  output logic op_ready_o,
  input  op_t  op_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);
`include "sorted_deadline_timer_bank_core_defines.svh"

  typedef enum logic [2:0] {
    StIdle, StRemove, StFind, StInsert, StPop, StRearm, StOut
  } state_e;

  state_e                   state_q;
  op_t                      op_q;
  logic [TickW-1:0]         tick_q;
  logic [TickW-1:0]         dl_q    [TimerCount];
  logic [PeriodW-1:0]       per_q   [TimerCount];
  logic [TimerCount-1:0]    mode_q, act_q;
  logic [IdW-1:0]           list_q  [TimerCount];
  logic [LenW-1:0]          len_q;
  logic [IdW-1:0]           pop_q   [TimerCount];
  logic [LenW-1:0]          npop_q, ridx_q, pos_q;
  logic [LenW-1:0]          sh_q;     // shift index while opening a slot
  logic [IdW-1:0]           cur_q;
  logic                     after_q;  // after remove: 0 done, 1 arm
  logic                     rv_q;
  rsp_t                     rsp_q;

  logic [TickW-1:0] cmp_diff, due_diff;
  logic [IdW-1:0]   pos_idx, head_id;
  logic [TickW-1:0] new_dl;

  assign pos_idx  = pos_q[IdW-1:0];
  assign head_id  = list_q[0];
  assign cmp_diff = dl_q[list_q[pos_idx]] - dl_q[cur_q];
  assign due_diff = tick_q - dl_q[head_id];
  assign new_dl   = tick_q + TickW'(per_q[cur_q]);

  assign op_ready_o  = (state_q == StIdle) && !rv_q;
  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  // Sequencer: one list slot per cycle for search, shift and pop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tick_q  <= '0;
      mode_q  <= '0;
      act_q   <= '0;
      len_q   <= '0;
      npop_q  <= '0;
      ridx_q  <= '0;
      pos_q   <= '0;
      sh_q    <= '0;
      cur_q   <= '0;
      after_q <= 1'b0;
      rv_q    <= 1'b0;
      for (int i = 0; i < TimerCount; i++) begin
        dl_q[i]  <= '0;
        per_q[i] <= '0;
      end
    end else begin
      if (rv_q && rsp_ready_i) rv_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (op_valid_i && !rv_q) begin
            op_q  <= op_i;
            cur_q <= op_i.id;
            pos_q <= '0;
            rsp_q <= '0;
            case (op_i.cmd)
              CmdTick: begin
                tick_q <= tick_q + 1'b1;
                npop_q <= '0;
                state_q <= StPop;
              end
              CmdInit: begin
                per_q[op_i.id] <= op_i.pval;
                mode_q[op_i.id] <= op_i.pmode;
                dl_q[op_i.id] <= '0;
                act_q[op_i.id] <= 1'b0;
                after_q <= 1'b0;
                if (act_q[op_i.id]) state_q <= StRemove;
                else begin
                  rsp_q.last <= 1'b1; rv_q <= 1'b1;
                end
              end
              CmdStart: begin
                after_q <= 1'b1;
                if (act_q[op_i.id]) state_q <= StRemove;
                else state_q <= StFind;
              end
              CmdStop: begin
                after_q <= 1'b0;
                if (act_q[op_i.id]) begin
                  act_q[op_i.id] <= 1'b0;
                  state_q <= StRemove;
                end else begin
                  rsp_q.status <= 1'b1; rsp_q.last <= 1'b1; rv_q <= 1'b1;
                end
              end
              CmdSetPeriod: begin
                per_q[op_i.id] <= op_i.pval;
                rsp_q.last <= 1'b1; rv_q <= 1'b1;
              end
              CmdSetMode: begin
                mode_q[op_i.id] <= op_i.pmode;
                rsp_q.last <= 1'b1; rv_q <= 1'b1;
              end
              CmdReadPer: begin
                rsp_q.read_period <= per_q[op_i.id];
                rsp_q.last <= 1'b1; rv_q <= 1'b1;
              end
              default: begin
                rsp_q.last <= 1'b1; rv_q <= 1'b1;
              end
            endcase
          end
        end
        // Walk to the entry, then shift the tail down one slot a cycle.
        StRemove: begin
          if (after_q && pos_q == '0) act_q[cur_q] <= 1'b0;
          if (pos_q + 1'b1 >= len_q) begin
            len_q <= len_q - 1'b1;
            pos_q <= '0;
            if (after_q) state_q <= StFind;
            else begin
              rsp_q.last <= 1'b1; rv_q <= 1'b1; state_q <= StIdle;
            end
          end else begin
            if (list_q[pos_idx] == cur_q) begin
              list_q[pos_idx] <= list_q[pos_idx + 1'b1];
              list_q[pos_idx + 1'b1] <= cur_q;
            end
            pos_q <= pos_q + 1'b1;
          end
        end
        // Arm and search for the insertion point, one entry a cycle.
        StFind: begin
          if (pos_q == '0 && !act_q[cur_q]) begin
            dl_q[cur_q]  <= new_dl;
            act_q[cur_q] <= 1'b1;
          end else if (pos_q >= len_q ||
                       (cmp_diff != '0 && cmp_diff < TickHalf)) begin
            state_q <= StInsert;
            sh_q    <= len_q;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        // Shift entries up from the end to open the slot.
        StInsert: begin
          if (sh_q == pos_q) begin
            list_q[pos_idx] <= cur_q;
            len_q <= len_q + 1'b1;
            if (op_q.cmd == CmdTick) begin
              state_q <= StRearm;
            end else begin
              rsp_q.last <= 1'b1; rv_q <= 1'b1; state_q <= StIdle;
            end
          end else begin
            list_q[sh_q[IdW-1:0]] <= list_q[sh_q[IdW-1:0] - 1'b1];
            sh_q <= sh_q - 1'b1;
          end
        end
        // Pop due heads; shift the list down one slot per cycle.
        StPop: begin
          if (len_q != '0 && due_diff < TickHalf) begin
            pop_q[npop_q[IdW-1:0]] <= head_id;
            npop_q <= npop_q + 1'b1;
            for (int i = 0; i < TimerCount - 1; i++) list_q[i] <= list_q[i+1];
            len_q <= len_q - 1'b1;
          end else begin
            ridx_q  <= '0;
            state_q <= StRearm;
            pos_q   <= '0;
          end
        end
        // Rearm popped periodic timers in order, deactivate the rest, then emit results.
        StRearm: begin
          if (ridx_q >= npop_q) begin
            ridx_q  <= '0;
            state_q <= StOut;
          end else begin
            cur_q <= pop_q[ridx_q[IdW-1:0]];
            pos_q <= '0;
            if (mode_q[pop_q[ridx_q[IdW-1:0]]]) begin
              act_q[pop_q[ridx_q[IdW-1:0]]] <= 1'b0;
              op_q.cmd <= CmdTick;
              state_q <= StFind;
            end else begin
              act_q[pop_q[ridx_q[IdW-1:0]]] <= 1'b0;
            end
            ridx_q <= ridx_q + 1'b1;
          end
        end
        StOut: begin
          if (!rv_q || rsp_ready_i) begin
            rv_q <= 1'b1;
            rsp_q <= '0;
            if (npop_q == '0) begin
              rsp_q.last <= 1'b1;
              state_q <= StIdle;
            end else begin
              rsp_q.expired    <= 1'b1;
              rsp_q.expired_id <= 3'(pop_q[ridx_q[IdW-1:0]]);
              if (ridx_q + 1'b1 == npop_q) begin
                rsp_q.last <= 1'b1;
                state_q <= StIdle;
              end
              ridx_q <= ridx_q + 1'b1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `SDT_ASSERT_IMP(a_len_bound, clk_i, rst_ni, 1'b1, len_q <= LenW'(TimerCount), "list overflow")
  `SDT_ASSERT_IMP(a_rsp_hold, clk_i, rst_ni, rv_q && !rsp_ready_i, !op_ready_o, "busy")
  `SDT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, op_valid_i && op_ready_o && op_i.cmd == CmdTick, state_q == StPop, "tick not popping")

endmodule

FILE: rtl/sorted_deadline_timer_bank_core.sv
// Top level of the sorted deadline timer bank.
//  channel | direction | handshake
//  req     | in        | req_valid_i / req_ready_o, payload req_i
//  rsp     | out       | rsp_valid_o / rsp_ready_i, payload rsp_o
// A request waits in a two-entry queue, then the back end runs it alone.
// Stop walks the list one slot a cycle; start removes, searches and shifts;
// a tick pops one due timer a cycle, rearms each periodic one with a list
// walk and emits one result a cycle while rsp_ready_i is high. Reset empties
// the list at once.
module sorted_deadline_timer_bank_core
  import sdtb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  logic op_valid, op_ready;
  op_t  op;

  sdtb_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .op_valid_o(op_valid), .op_ready_i(op_ready), .op_o(op)
  );

  sdtb_back u_back (
    .clk_i, .rst_ni, .op_valid_i(op_valid), .op_ready_o(op_ready), .op_i(op),
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

endmodule

FILE: test/sdtb_checker.sv
// Checker for the timer bank: predicts responses per request and compares them.
`timescale 1ns / 1ps
module sdtb_checker
  import sdtb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  req_t        req_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  rsp_t        rsp_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  // Shadow timer state
  logic [31:0]        tick_q;
  logic [31:0]        due_at [TimerCount];
  logic [PeriodW-1:0] per [TimerCount];
  logic               periodic [TimerCount];
  logic               running [TimerCount];
  logic [2:0]         order [TimerCount];
  int unsigned        order_len;

  rsp_t expected_rsps[$];
  int unsigned mismatches;

  assign errors_o  = mismatches;
  assign pending_o = expected_rsps.size();

  function automatic void unlink(input logic [2:0] id);
    int k;
    int hit;
    hit = -1;
    for (k = 0; k < order_len; k++) if (hit < 0 && order[k] == id) hit = k;
    if (hit >= 0) begin
      for (k = hit; k + 1 < order_len; k++) order[k] = order[k+1];
      order_len--;
    end
  endfunction

  // Compute deadline and insert after equal ones
  function automatic void schedule(input logic [2:0] id);
    int pos;
    int j;
    logic [31:0] diff;
    due_at[id] = tick_q + {1'b0, per[id]};
    pos = order_len;
    for (j = order_len - 1; j >= 0; j--) begin
      diff = due_at[order[j]] - due_at[id];
      if (diff != 0 && diff < TickHalf) pos = j;
    end
    for (j = order_len; j > pos; j--) order[j] = order[j-1];
    order[pos] = id;
    order_len++;
    running[id] = 1'b1;
  endfunction

  function automatic void predict(input req_t rq);
    logic [2:0] fired[$];
    rsp_t r;
    int k;
    r = '0;
    r.last = 1'b1;
    if (cmd_e'(rq.command) == CmdTick) begin
      tick_q = tick_q + 1;
      while (order_len > 0 && (tick_q - due_at[order[0]]) < TickHalf) begin
        fired.push_back(order[0]);
        unlink(order[0]);
      end
      for (k = 0; k < fired.size(); k++) begin
        if (periodic[fired[k]]) schedule(fired[k]);
        else running[fired[k]] = 1'b0;
      end
      if (fired.size() == 0) expected_rsps.push_back(r);
      for (k = 0; k < fired.size(); k++) begin
        r = '0;
        r.expired = 1'b1;
        r.expired_id = fired[k];
        r.last = (k + 1 == fired.size());
        expected_rsps.push_back(r);
      end
      return;
    end
    case (cmd_e'(rq.command))
      CmdInit: begin
        if (running[rq.timer_id]) unlink(rq.timer_id);
        running[rq.timer_id] = 1'b0;
        per[rq.timer_id] = rq.period_value;
        periodic[rq.timer_id] = rq.periodic_mode;
        due_at[rq.timer_id] = '0;
      end
      CmdStart: begin
        if (running[rq.timer_id]) unlink(rq.timer_id);
        schedule(rq.timer_id);
      end
      CmdStop: begin
        if (!running[rq.timer_id]) r.status = 1'b1;
        else begin
          unlink(rq.timer_id);
          running[rq.timer_id] = 1'b0;
        end
      end
      CmdSetPeriod: per[rq.timer_id] = rq.period_value;
      CmdSetMode:   periodic[rq.timer_id] = rq.periodic_mode;
      CmdReadPer:   r.read_period = per[rq.timer_id];
      default: ;
    endcase
    expected_rsps.push_back(r);
  endfunction

  // Watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      tick_q = '0;
      order_len = 0;
      for (int i = 0; i < TimerCount; i++) begin
        due_at[i] = '0;
        per[i] = '0;
        periodic[i] = 1'b0;
        running[i] = 1'b0;
        order[i] = '0;
      end
      expected_rsps.delete();
      mismatches = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", rsp_i);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", want, rsp_i);
          end
        end
      end
      if (req_valid_i && req_ready_i) predict(req_i);
    end
  end

endmodule

FILE: test/tb.sv
// Testbench top: drives requests and response backpressure, reports the verdict.
`timescale 1ns / 1ps
module tb;
  import sdtb_pkg::*;

  logic clk;
  logic rst_n;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  int unsigned errors;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycles = 0;

  sorted_deadline_timer_bank_core DUT (
    .clk_i(clk), .rst_ni(rst_n), .req_valid_i(req_valid), .req_ready_o(req_ready),
    .req_i(req), .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp)
  );

  sdtb_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .req_valid_i(req_valid), .req_ready_i(req_ready),
    .req_i(req), .rsp_valid_i(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_i(rsp),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Receiver backpressure
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Send one request, holding valid until accepted
  task automatic issue(input cmd_e c, input logic [2:0] id, input logic [30:0] pv,
                       input logic pm);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{command: c, timer_id: id, period_value: pv, periodic_mode: pm};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [30:0] rand_period();
    case ($urandom_range(9))
      0:       return 31'($urandom());
      1:       return 31'h7FFF_FFFF;
      2:       return 31'h7FFF_FFF0 + 31'($urandom_range(15));
      default: return 31'($urandom_range(6));
    endcase
  endfunction

  task automatic random_phase(input int n);
    cmd_e c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(15))
        0, 1, 2, 3, 4, 5: c = CmdTick;
        6, 7:   c = CmdInit;
        8, 9, 10: c = CmdStart;
        11:     c = CmdStop;
        12:     c = CmdSetPeriod;
        13:     c = CmdSetMode;
        14:     c = CmdReadPer;
        default: c = ($urandom_range(3) == 0) ? CmdNone : CmdTick;
      endcase
      issue(c, 3'($urandom_range(7)), rand_period(), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    req_valid = 1'b0;
    req = '0;
    send_idle_pct = 14;
    recv_idle_pct = 55;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: stop of idle timer, zero period periodic, equal deadlines, extremes
    issue(CmdStop, 3'd0, 31'd0, 1'b0);
    issue(CmdTick, 3'd7, 31'h7FFF_FFFF, 1'b1);
    issue(CmdInit, 3'd0, 31'd0, 1'b1);
    issue(CmdInit, 3'd1, 31'd2, 1'b0);
    issue(CmdInit, 3'd2, 31'd2, 1'b1);
    issue(CmdInit, 3'd7, 31'h7FFF_FFFF, 1'b1);
    issue(CmdStart, 3'd1, 31'd0, 1'b0);
    issue(CmdStart, 3'd2, 31'd0, 1'b0);
    issue(CmdStart, 3'd0, 31'd0, 1'b0);
    issue(CmdStart, 3'd7, 31'd0, 1'b0);
    issue(CmdTick, 3'd0, 31'd0, 1'b0);
    issue(CmdTick, 3'd0, 31'd0, 1'b0);
    issue(CmdStart, 3'd2, 31'd0, 1'b0);
    issue(CmdReadPer, 3'd7, 31'd0, 1'b0);
    issue(CmdSetPeriod, 3'd3, 31'h5555_5555, 1'b0);
    issue(CmdReadPer, 3'd3, 31'h2AAA_AAAA, 1'b1);
    issue(CmdSetMode, 3'd0, 31'd0, 1'b0);
    issue(CmdTick, 3'd0, 31'd0, 1'b0);
    issue(CmdStop, 3'd2, 31'd0, 1'b0);
    issue(CmdStop, 3'd7, 31'd0, 1'b0);
    issue(CmdInit, 3'd1, 31'd1, 1'b1);
    issue(CmdStart, 3'd1, 31'd0, 1'b0);
    issue(CmdInit, 3'd1, 31'd1, 1'b0);
    issue(CmdNone, 3'd5, 31'h7FFF_FFFF, 1'b1);
    issue(CmdTick, 3'd0, 31'd0, 1'b0);

    random_phase(150);
    send_idle_pct = 55;
    recv_idle_pct = 14;
    random_phase(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(150);
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/sdtb_pkg.sv
rtl/sdtb_front.sv
rtl/sdtb_back.sv
rtl/sorted_deadline_timer_bank_core.sv
test/sdtb_checker.sv
test/tb.sv
